### rtl/core/svc_pkg.sv
package svc_pkg;

	// Volume geometry
	localparam int MAX_DIM    = 32;
	localparam int MAX_RADIUS = 15;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int ADDR_W     = 3 * DIM_W;

	// Field widths
	localparam int RAD_W   = 4;
	localparam int LABEL_W = 8;
	localparam int CFG_W   = 6;
	localparam int IDX_W   = 2;
	localparam int SDATA_W = 32;
	localparam int MDATA_W = 8;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd0;
	localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd2;

	// Item kinds carried in tuser
	localparam logic MODE_CARVE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_en;
		logic load_item;
		logic setup;
		logic step;
		logic rd_en;
		logic out_load;
	} svc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic box_empty;
		logic walk_last;
	} svc_sts_t;

endpackage

### rtl/core/sphere_voxel_carver.sv
// Sphere voxel carver: holds a 32x32x32 volume of byte labels, voxel (z,y,x) at
// address (z*32+y)*32+x. A carve beat (tuser 0) writes its label into every voxel
// of its clipped bounding box that lies within radius of the centre; a read beat
// (tuser 1) returns the label of one voxel. Every input beat gives exactly one
// output beat: the read label with tuser 1, or label zero with tuser 0 once a carve
// is finished. Items are handled one at a time. A carve walks every voxel of its
// box, the ball's bounding box clipped to the configured size; an empty box is
// not walked. The walk rate is set by the single write port of the label memory,
// which takes one voxel per cycle. After reset the block sweeps the memory to
// zero, one voxel a cycle, with s_tready low; size registers may be written
// meanwhile. A finished result waits in the output register while the next beat
// is taken. Write the size registers only while the block is idle.
module sphere_voxel_carver (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration
	input  logic                         cfg_wr_en,
	input  logic [svc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [svc_pkg::CFG_W-1:0]    cfg_data,
	// Input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// s_tdata: center_z[4:0], center_y[9:5], center_x[14:10], ball_radius[18:15],
	//          fill_label[26:19], zero pad[31:27]
	input  logic [svc_pkg::SDATA_W-1:0]  s_tdata,
	// s_tuser: mode[0]
	input  logic                         s_tuser,
	// Result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// m_tdata: voxel_label[7:0]
	output logic [svc_pkg::MDATA_W-1:0]  m_tdata,
	// m_tuser: was_read[0]
	output logic                         m_tuser
);
	import svc_pkg::*;

	svc_cmd_t cmd;
	svc_sts_t sts;

	// Sequencer: clear sweep, item acceptance, box walk and result hand-off
	svc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_mode   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Size registers, box bounds, walker, distance test, label memory, result register
	svc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_mode    (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Only one item in flight: an accepted beat drops ready at once
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second beat accepted while an item is in flight");

	// A carve result always carries label zero
	a_carve_label_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("carve result with non-zero label");

	// A read taken with the output free is answered through the READ and DONE states with no wait
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser && !m_tvalid) |-> ##3 (m_tvalid && m_tuser))
		else $error("read result late or missing");

endmodule

### rtl/core/svc_ctrl.sv
module svc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            s_mode,
	output logic            m_tvalid,
	input  logic            m_tready,
	output svc_pkg::svc_cmd_t cmd,
	input  svc_pkg::svc_sts_t sts
);
	import svc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_CARVE,
		ST_READ,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clear_en  = 1'b1;
			ST_IDLE:  cmd.load_item = s_tvalid;
			ST_SETUP: cmd.setup     = 1'b1;
			ST_CARVE: cmd.step      = !sts.box_empty;
			ST_READ:  cmd.rd_en     = 1'b1;
			ST_DONE:  cmd.out_load  = !m_tvalid_q || m_tready;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= (s_mode == MODE_READ) ? ST_READ : ST_SETUP;
				end
				ST_SETUP: state_q <= ST_CARVE;
				ST_CARVE: begin
					if (sts.box_empty || sts.walk_last)
						state_q <= ST_DONE;
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (cmd.out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

### rtl/core/svc_datapath.sv
module svc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [svc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [svc_pkg::CFG_W-1:0]    cfg_data,
	input  logic [svc_pkg::SDATA_W-1:0]  s_tdata,
	input  logic                         s_mode,
	input  svc_pkg::svc_cmd_t            cmd,
	output svc_pkg::svc_sts_t            sts,
	output logic [svc_pkg::MDATA_W-1:0]  m_tdata,
	output logic                         m_tuser
);
	import svc_pkg::*;

	localparam int SW  = CFG_W + 1;
	localparam int SQW = 2 * DIM_W;
	localparam int SUMW = SQW + 2;

	typedef struct packed {
		logic             empty;
		logic [DIM_W-1:0] lo;
		logic [DIM_W-1:0] hi;
	} bnd_t;

	// Clip one axis of the bounding box to [0, n-1]
	function automatic bnd_t axis_bounds(logic [DIM_W-1:0] c, logic [RAD_W-1:0] r,
			logic [CFG_W-1:0] size);
		logic [CFG_W-1:0]    n;
		logic signed [SW-1:0] cs;
		logic signed [SW-1:0] rs;
		logic signed [SW-1:0] lo_s;
		logic signed [SW-1:0] hi_s;
		logic signed [SW-1:0] top_s;
		bnd_t                b;
		n     = (size > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : size;
		cs    = signed'(SW'(c));
		rs    = signed'(SW'(r));
		lo_s  = cs - rs;
		if (lo_s < 0)
			lo_s = '0;
		hi_s  = cs + rs;
		top_s = signed'(SW'(n)) - SW'(1);
		if (top_s < hi_s)
			hi_s = top_s;
		b.empty = hi_s < lo_s;
		b.lo    = lo_s[DIM_W-1:0];
		b.hi    = hi_s[DIM_W-1:0];
		return b;
	endfunction

	function automatic logic [SQW-1:0] sq_dist(logic [DIM_W-1:0] a, logic [DIM_W-1:0] b);
		logic [DIM_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return SQW'(d) * SQW'(d);
	endfunction

	logic [LABEL_W-1:0] mem [0:(1 << ADDR_W)-1];

	logic [CFG_W-1:0]   size_z_q, size_y_q, size_x_q;
	logic [DIM_W-1:0]   cz_q, cy_q, cx_q;
	logic [RAD_W-1:0]   r_q;
	logic [LABEL_W-1:0] label_q;
	logic               mode_q;
	logic [ADDR_W-1:0]  clr_q;
	bnd_t               bz_q, by_q, bx_q;
	bnd_t               bnd_z, bnd_y, bnd_x;
	logic               box_empty;
	logic [DIM_W-1:0]   wz_q, wy_q, wx_q;
	logic [LABEL_W-1:0] rdata_q;
	logic [LABEL_W-1:0] out_label_q;
	logic               out_read_q;

	logic [RAD_W-1:0]   r_in;
	logic [SQW-1:0]     rr;
	logic [SUMW-1:0]    dist_sq;
	logic               in_ball;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [LABEL_W-1:0] wr_data;
	logic               x_end, y_end, z_end;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_z_q <= CFG_W'(MAX_DIM);
			size_y_q <= CFG_W'(MAX_DIM);
			size_x_q <= CFG_W'(MAX_DIM);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SIZE_Z: size_z_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_X: size_x_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clear_en)
			clr_q <= clr_q + ADDR_W'(1);
	end

	assign r_in = s_tdata[3*DIM_W +: RAD_W];

	assign bnd_z = axis_bounds(cz_q, r_q, size_z_q);
	assign bnd_y = axis_bounds(cy_q, r_q, size_y_q);
	assign bnd_x = axis_bounds(cx_q, r_q, size_x_q);

	// Item capture and bounding box
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cz_q    <= s_tdata[0 +: DIM_W];
			cy_q    <= s_tdata[DIM_W +: DIM_W];
			cx_q    <= s_tdata[2*DIM_W +: DIM_W];
			r_q     <= (r_in > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_in;
			label_q <= s_tdata[3*DIM_W+RAD_W +: LABEL_W];
			mode_q  <= s_mode;
		end
		if (cmd.setup) begin
			bz_q    <= bnd_z;
			by_q    <= bnd_y;
			bx_q    <= bnd_x;
		end
	end

	assign box_empty = bz_q.empty || by_q.empty || bx_q.empty;

	// Box walker: x fastest, then y, then z
	assign x_end = (wx_q == bx_q.hi);
	assign y_end = (wy_q == by_q.hi);
	assign z_end = (wz_q == bz_q.hi);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			wz_q <= bnd_z.lo;
			wy_q <= bnd_y.lo;
			wx_q <= bnd_x.lo;
		end else if (cmd.step) begin
			if (x_end) begin
				wx_q <= bx_q.lo;
				if (y_end) begin
					wy_q <= by_q.lo;
					wz_q <= wz_q + DIM_W'(1);
				end else begin
					wy_q <= wy_q + DIM_W'(1);
				end
			end else begin
				wx_q <= wx_q + DIM_W'(1);
			end
		end
	end

	assign rr      = SQW'(r_q) * SQW'(r_q);
	assign dist_sq = SUMW'(sq_dist(wz_q, cz_q)) + SUMW'(sq_dist(wy_q, cy_q))
		+ SUMW'(sq_dist(wx_q, cx_q));
	assign in_ball = dist_sq <= SUMW'(rr);

	always_comb begin
		if (cmd.clear_en) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = cmd.step && in_ball;
			wr_addr = {wz_q, wy_q, wx_q};
			wr_data = label_q;
		end
	end

	// Label volume, z-major with fixed strides
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rdata_q <= mem[{cz_q, cy_q, cx_q}];
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_label_q <= (mode_q == MODE_READ) ? rdata_q : '0;
			out_read_q  <= mode_q;
		end
	end

	assign sts.clear_last = (clr_q == {ADDR_W{1'b1}});
	assign sts.box_empty  = box_empty;
	assign sts.walk_last  = x_end && y_end && z_end;

	assign m_tdata = MDATA_W'(out_label_q);
	assign m_tuser = out_read_q;

endmodule
